// ===== sv/rrht_pkg.sv =====
// Shared types and codes for the rectangular region height table.
`timescale 1ns / 1ps
`default_nettype none

package rrht_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_t;

  // Operation codes
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_FIND  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_MATCH = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;
  localparam logic [1:0] STAT_INACTIVE = 2'd3;

  // Entry count register
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef logic [CFG_W-1:0] count_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         entry_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_z;
    logic [30:0]        span_x;
    logic [30:0]        span_z;
    logic signed [31:0] height_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         match_index;
    logic signed [31:0] height_out;
  } out_item_t;

  // One stored rectangle
  typedef struct packed {
    logic signed [31:0] low_x;
    logic signed [31:0] low_z;
    logic [30:0]        span_x;
    logic [30:0]        span_z;
  } region_geom_t;

endpackage

`default_nettype wire

// ===== sv/rect_region_height_table.sv =====
// Top level of the rectangular region height table.
// Items are taken when start is high and busy is low; each item yields one
// result, shown for a single cycle with out_valid high, and the receiver
// cannot stall it. After the accepting edge an item passes through DECODE;
// set, write and out-of-range items then go to DONE, read goes through READ
// to DONE, and find stays in SCAN until the first hit or the end of the
// entries in effect and then goes to DONE, which shows the result. The
// find time is set by the one shared rectangle comparator walking the table
// one entry per cycle behind the registered read port of the region RAM.
// busy drops the cycle after the strobe, so the next item can be taken then.
// Reset clears all active flags at once and sets the entry count to 16.
`timescale 1ns / 1ps
`default_nettype none

module rect_region_height_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rrht_pkg::in_item_t           in_item,
  output logic                         out_valid,
  output rrht_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [rrht_pkg::CFG_W-1:0]   cfg_wdata
);
  import rrht_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  state_t                 state_r, state_nxt;
  in_item_t               item_r, item_nxt;
  count_t                 entries_in_use_r;
  count_t                 live_cnt;
  count_t                 cnt_r, cnt_nxt;
  count_t                 scan_r, scan_nxt;
  count_t                 cmp_idx_r, cmp_idx_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [MAX_ENTRIES-1:0] active_r, active_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [3:0]             match_r, match_nxt;
  logic signed [31:0]     hout_r, hout_nxt;

  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic                   geom_we;
  logic                   height_we;
  region_geom_t           geom_wdata;
  region_geom_t           geom_rdata;
  logic [31:0]            height_rdata;
  logic                   geom_hit;
  logic                   cmp_hit;
  logic                   issuing;
  logic                   in_range;

  // Entry count in effect saturates at the table depth
  assign live_cnt = (32'(entries_in_use_r) > MAX_ENTRIES) ? count_t'(MAX_ENTRIES)
                                                         : entries_in_use_r;

  assign in_range = ({1'b0, item_r.entry_index} < cnt_r);
  assign issuing  = (scan_r < cnt_r);
  assign wr_addr  = IDX_W'(item_r.entry_index);

  assign geom_wdata = '{low_x:  item_r.coord_x,
                        low_z:  item_r.coord_z,
                        span_x: item_r.span_x,
                        span_z: item_r.span_z};

  // Region geometry store
  rrht_ram #(
    .WIDTH ($bits(region_geom_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_geom_ram (
    .clk   (clk),
    .we    (geom_we),
    .waddr (wr_addr),
    .wdata (geom_wdata),
    .raddr (rd_addr),
    .rdata (geom_rdata)
  );

  // Region height store
  rrht_ram #(
    .WIDTH (32),
    .DEPTH (MAX_ENTRIES)
  ) u_height_ram (
    .clk   (clk),
    .we    (height_we),
    .waddr (wr_addr),
    .wdata (item_r.height_value),
    .raddr (rd_addr),
    .rdata (height_rdata)
  );

  // Shared comparator sees the entry read in the previous scan cycle
  rrht_hit_unit u_hit (
    .point_x (item_r.coord_x),
    .point_z (item_r.coord_z),
    .geom    (geom_rdata),
    .hit     (geom_hit)
  );

  assign cmp_hit = cmp_vld_r && active_r[IDX_W'(cmp_idx_r)] && geom_hit;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (item_r.operation == OP_FIND) begin
          state_nxt = ST_SCAN;
        end else if (!in_range) begin
          state_nxt = ST_DONE;
        end else if (item_r.operation == OP_READ) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (cmp_hit || (!issuing && !cmp_vld_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    item_nxt    = item_r;
    cnt_nxt     = cnt_r;
    scan_nxt    = scan_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    active_nxt  = active_r;
    status_nxt  = status_r;
    match_nxt   = match_r;
    hout_nxt    = hout_r;
    rd_addr     = IDX_W'(item_r.entry_index);
    geom_we     = 1'b0;
    height_we   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // Capture the item and clear the result
        if (start) begin
          item_nxt   = in_item;
          cnt_nxt    = live_cnt;
          scan_nxt   = '0;
          status_nxt = STAT_OK;
          match_nxt  = '0;
          hout_nxt   = '0;
        end
      end
      ST_DECODE: begin
        priority if (item_r.operation == OP_FIND) begin
          scan_nxt = '0;
        end else if (!in_range) begin
          status_nxt = STAT_RANGE;
        end else if (item_r.operation == OP_SET) begin
          geom_we             = 1'b1;
          height_we           = 1'b1;
          active_nxt[wr_addr] = 1'b1;
        end else if (item_r.operation == OP_WRITE) begin
          height_we = 1'b1;
        end else begin
          // Read: height RAM address is already the entry index
          rd_addr = wr_addr;
        end
      end
      ST_SCAN: begin
        // Issue the next entry while the previous one is compared
        rd_addr = IDX_W'(scan_r);
        if (issuing) begin
          scan_nxt    = scan_r + 5'd1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r;
        end
        priority if (cmp_hit) begin
          status_nxt  = STAT_OK;
          match_nxt   = cmp_idx_r[3:0];
          cmp_vld_nxt = 1'b0;
        end else if (!issuing && !cmp_vld_r) begin
          status_nxt = STAT_NO_MATCH;
        end else begin
          status_nxt = status_r;
        end
      end
      ST_READ: begin
        if (active_r[wr_addr]) begin
          hout_nxt = signed'(height_rdata);
        end else begin
          status_nxt = STAT_INACTIVE;
        end
      end
      ST_DONE: begin
        status_nxt = status_r;
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      active_r         <= '0;
      cmp_vld_r        <= 1'b0;
      entries_in_use_r <= CFG_RESET;
    end else begin
      state_r   <= state_nxt;
      active_r  <= active_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if (cfg_we) begin
        entries_in_use_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    cnt_r     <= cnt_nxt;
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    status_r  <= status_nxt;
    match_r   <= match_nxt;
    hout_r    <= hout_nxt;
  end

  // Drive the ports
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_item  = '{status: status_r, match_index: match_r, height_out: hout_r};

endmodule

`default_nettype wire

// ===== sv/rrht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rrht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/rrht_hit_unit.sv =====
// Point-in-rectangle comparator shared by every step of the table scan.
`timescale 1ns / 1ps
`default_nettype none

module rrht_hit_unit (
  input  logic signed [31:0]    point_x,
  input  logic signed [31:0]    point_z,
  input  rrht_pkg::region_geom_t geom,
  output logic                  hit
);
  import rrht_pkg::*;

  logic [32:0] dx;
  logic [32:0] dz;
  logic        hit_x;
  logic        hit_z;

  // Offset of the point from the low corner, one bit wider so it never wraps
  assign dx = {point_x[31], point_x} - {geom.low_x[31], geom.low_x};
  assign dz = {point_z[31], point_z} - {geom.low_z[31], geom.low_z};

  // Inside when 0 <= offset < span; a zero span matches nothing
  assign hit_x = !dx[32] && (dx[31:0] < {1'b0, geom.span_x});
  assign hit_z = !dz[32] && (dz[31:0] < {1'b0, geom.span_z});
  assign hit   = hit_x && hit_z;

endmodule

`default_nettype wire

// ===== sv/rrht_chk.sv =====
// Port-level checks for the rectangular region height table, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module rrht_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input rrht_pkg::out_item_t        out_item
);
  import rrht_pkg::*;

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // A result is only shown while the item is still owned
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // One strobe per item, then ready again
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not a single cycle or block stays busy");

  // Failing items carry zero index and height
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != STAT_OK)) |->
      ((out_item.match_index == 4'd0) && (out_item.height_out == 32'sd0)))
    else $error("nonzero payload on a failing result");

endmodule

bind rect_region_height_table rrht_chk u_rrht_chk (.*);

`default_nettype wire

// ===== tb/rect_region_height_table_tb.sv =====
// Self-checking testbench for the rectangular region height table.
`timescale 1ns / 1ps

module rect_region_height_table_tb;
  import rrht_pkg::*;

  // Shadow copy of the region table; predicts one reply per request and checks it
  class region_table_board;
    logic [31:0] low_x [16];
    logic [31:0] low_z [16];
    logic [30:0] span_x [16];
    logic [30:0] span_z [16];
    logic [31:0] height [16];
    bit          active [16];
    int unsigned entry_count;
    out_item_t   expected_replies [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned finds_hit;
    int unsigned finds_missed;
    int unsigned range_errs;
    int unsigned inactive_reads;

    function new();
      foreach (active[i]) active[i] = 1'b0;
      entry_count = CFG_RESET;
      errors = 0;
      checked = 0;
      finds_hit = 0;
      finds_missed = 0;
      range_errs = 0;
      inactive_reads = 0;
    endfunction

    function void set_count(input count_t v);
      entry_count = v;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    // Apply one accepted request to the shadow table and queue its reply
    function void note_item(input in_item_t it);
      out_item_t   r;
      int unsigned live;
      longint      px, pz, lx, lz, hx, hz;
      bit          found;
      r = '0;
      found = 1'b0;
      live = (entry_count > 16) ? 16 : entry_count;
      if (it.operation == OP_FIND) begin
        r.status = STAT_NO_MATCH;
        px = longint'($signed(it.coord_x));
        pz = longint'($signed(it.coord_z));
        for (int i = 0; i < live; i++) begin
          if (!found && active[i]) begin
            lx = longint'($signed(low_x[i]));
            lz = longint'($signed(low_z[i]));
            // ends at full precision, no wrap
            hx = lx + longint'({1'b0, span_x[i]}) - 1;
            hz = lz + longint'({1'b0, span_z[i]}) - 1;
            if (lx <= px && px <= hx && lz <= pz && pz <= hz) begin
              found = 1'b1;
              r.status = STAT_OK;
              r.match_index = i[3:0];
            end
          end
        end
        if (found) finds_hit++;
        else finds_missed++;
      end else if (it.entry_index >= live) begin
        r.status = STAT_RANGE;
        range_errs++;
      end else begin
        case (it.operation)
          OP_SET: begin
            low_x[it.entry_index]  = it.coord_x;
            low_z[it.entry_index]  = it.coord_z;
            span_x[it.entry_index] = it.span_x;
            span_z[it.entry_index] = it.span_z;
            height[it.entry_index] = it.height_value;
            active[it.entry_index] = 1'b1;
          end
          OP_READ: begin
            if (!active[it.entry_index]) begin
              r.status = STAT_INACTIVE;
              inactive_reads++;
            end else begin
              r.height_out = height[it.entry_index];
            end
          end
          default: begin
            // height lands even on an inactive entry
            height[it.entry_index] = it.height_value;
          end
        endcase
      end
      expected_replies.push_back(r);
    endfunction

    // Compare one reply, field by field, with the oldest prediction
    function void check_result(input out_item_t got);
      out_item_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result status %0d match %0d height %0d",
                 $time, got.status, got.match_index, got.height_out);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.match_index !== want.match_index) begin
        $display("%0t: match_index expected %0d got %0d",
                 $time, want.match_index, got.match_index);
        errors++;
      end
      if (got.height_out !== want.height_out) begin
        $display("%0t: height_out expected %0d got %0d",
                 $time, want.height_out, got.height_out);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  req = '0;
  logic      out_valid;
  out_item_t rsp;
  logic      cfg_we = 1'b0;
  count_t    cfg_wdata = '0;

  region_table_board board;
  int unsigned       idle_pct = 0;
  int unsigned       sent = 0;
  int unsigned       phase_count [7] = '{16, 7, 31, 1, 0, 17, 11};
  int unsigned       phase_idle [7]  = '{0, 75, 14, 75, 0, 14, 75};

  rect_region_height_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (req),
    .out_valid (out_valid),
    .out_item  (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Observe accepted items, results and register writes at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_result(rsp);
      if (start && !busy) board.note_item(req);
      if (cfg_we) board.set_count(cfg_wdata);
    end
  end

  function automatic in_item_t make_item(input logic [1:0] op, input int unsigned idx,
                                         input logic [31:0] x, input logic [31:0] z,
                                         input logic [30:0] sx, input logic [30:0] sz,
                                         input logic [31:0] h);
    in_item_t it;
    it.operation    = op;
    it.entry_index  = idx[3:0];
    it.coord_x      = x;
    it.coord_z      = z;
    it.span_x       = sx;
    it.span_z       = sz;
    it.height_value = h;
    return it;
  endfunction

  // Mostly a small window so finds hit, now and then anything
  function automatic logic [31:0] pick_coord();
    int unsigned k;
    k = $urandom_range(19);
    if (k < 16) return $urandom_range(40) - 20;
    if (k == 16) return 32'h8000_0000;
    if (k == 17) return 32'h7fff_ffff;
    return $urandom();
  endfunction

  function automatic logic [30:0] pick_span();
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return '0;
    if (k < 8) return 31'($urandom_range(16));
    return 31'($urandom());
  endfunction

  function automatic in_item_t rand_request(input int unsigned live);
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) it.operation = OP_SET;
    else if (pick < 70) it.operation = OP_FIND;
    else if (pick < 85) it.operation = OP_READ;
    else it.operation = OP_WRITE;
    if (live > 0 && $urandom_range(9) < 8) it.entry_index = 4'($urandom_range(live - 1));
    else it.entry_index = 4'($urandom());
    it.coord_x      = pick_coord();
    it.coord_z      = pick_coord();
    it.span_x       = pick_span();
    it.span_z       = pick_span();
    it.height_value = $urandom();
    return it;
  endfunction

  // Hold start high until the item is taken; idle first at random
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Drop start and wait until every outstanding result is back
  task automatic drain_table();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(input int unsigned v);
    cfg_wdata <= count_t'(v);
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned live;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: empty table, inactive entries, extreme rectangles, first match
    send_item(make_item(OP_FIND, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_WRITE, 1, 0, 0, 0, 0, 32'h7fff_ffff));
    send_item(make_item(OP_READ, 1, 0, 0, 0, 0, 0));
    send_item(make_item(OP_SET, 0, 32'h8000_0000, 32'h8000_0000,
                        31'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000));
    send_item(make_item(OP_SET, 15, 32'h7fff_ffff, 32'h7fff_ffff,
                        31'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff));
    send_item(make_item(OP_SET, 3, 0, 0, 0, 5, 3));
    send_item(make_item(OP_SET, 5, -10, -10, 21, 21, 55));
    send_item(make_item(OP_SET, 6, 0, 0, 1, 1, 66));
    send_item(make_item(OP_FIND, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0));
    send_item(make_item(OP_FIND, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    send_item(make_item(OP_FIND, 0, -2, -2, 0, 0, 0));
    send_item(make_item(OP_FIND, 0, -1, -1, 0, 0, 0));
    send_item(make_item(OP_FIND, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_FIND, 0, 10, 10, 0, 0, 0));
    send_item(make_item(OP_FIND, 0, 11, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 15, 0, 0, 0, 0, 0));
    send_item(make_item(OP_WRITE, 15, 0, 0, 0, 0, 32'h1234_5678));
    send_item(make_item(OP_READ, 15, 0, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 3, 0, 0, 0, 0, 0));
    drain_table();

    // Shrink the table: out-of-range indexes, hidden entries skipped by find
    write_count(4);
    send_item(make_item(OP_SET, 7, 1, 1, 1, 1, 1));
    send_item(make_item(OP_READ, 15, 0, 0, 0, 0, 0));
    send_item(make_item(OP_WRITE, 4, 0, 0, 0, 0, 9));
    send_item(make_item(OP_FIND, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_FIND, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    drain_table();
    write_count(0);
    send_item(make_item(OP_FIND, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0));
    drain_table();
    // Count above the table size saturates
    write_count(31);
    send_item(make_item(OP_READ, 15, 0, 0, 0, 0, 0));
    send_item(make_item(OP_FIND, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0));
    drain_table();

    // Random phases, each with its own entry count and sender idling
    for (int p = 0; p < 7; p++) begin
      write_count(phase_count[p]);
      idle_pct = phase_idle[p];
      live = (phase_count[p] > 16) ? 16 : phase_count[p];
      for (int n = 0; n < 100; n++) begin
        if (n == 50) drain_table();
        send_item(rand_request(live));
      end
      drain_table();
    end

    $display("covered %0d items, %0d results: %0d find hits, %0d find misses,",
             sent, board.checked, board.finds_hit, board.finds_missed);
    $display("%0d out-of-range and %0d inactive reads, entry counts 0 to 31",
             board.range_errs, board.inactive_reads);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("rect_region_height_table_tb: done, clean");
    end else begin
      $display("rect_region_height_table_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("rect_region_height_table_tb: done, errors");
    $finish;
  end

endmodule
